@@ sv/udpf_pkg.sv @@
// Shared constants, types and status codes for the UDP port drop filter.
`default_nettype none

package udpf_pkg;

   // Frame length counter width and its saturation value
   localparam int LEN_W = 14;
   localparam logic [LEN_W-1:0] POS_MAX = {LEN_W{1'b1}};

   // Header layout and protocol constants
   localparam int CNT_W = 64;
   localparam int PORT_W = 16;
   localparam int L4_W = 7;
   localparam logic [LEN_W-1:0] ETH_LEN = LEN_W'(14);
   localparam logic [LEN_W-1:0] ETH_IP_MIN = LEN_W'(34);
   localparam logic [LEN_W-1:0] POS_ETYPE_HI = LEN_W'(12);
   localparam logic [LEN_W-1:0] POS_ETYPE_LO = LEN_W'(13);
   localparam logic [LEN_W-1:0] POS_IHL = LEN_W'(14);
   localparam logic [LEN_W-1:0] POS_FRAG_HI = LEN_W'(20);
   localparam logic [LEN_W-1:0] POS_FRAG_LO = LEN_W'(21);
   localparam logic [LEN_W-1:0] POS_PROTO = LEN_W'(23);
   localparam logic [LEN_W-1:0] POS_L4_MIN = LEN_W'(16);
   localparam logic [L4_W-1:0] L4_BASE = L4_W'(14);
   localparam logic [LEN_W-1:0] TCP_LEN = LEN_W'(20);
   localparam logic [LEN_W-1:0] UDP_LEN = LEN_W'(8);
   localparam logic [3:0] IHL_MIN = 4'd5;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] FRAG_MASK = 16'h3FFF;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [PORT_W-1:0] DEFAULT_PORT = PORT_W'(5201);

   // Configuration register indexes
   localparam logic CSR_FILTER_ENABLE = 1'b0;
   localparam logic CSR_TARGET_PORT = 1'b1;

   // Per-frame outcome codes
   typedef enum logic [3:0] {
      ST_PASS      = 4'd0,
      ST_DROP      = 4'd1,
      ST_SHORT_ETH = 4'd2,
      ST_NOT_IPV4  = 4'd3,
      ST_SHORT_IP  = 4'd4,
      ST_BAD_IHL   = 4'd5,
      ST_OPT_PAST  = 4'd6,
      ST_FRAGMENT  = 4'd7,
      ST_SHORT_L4  = 4'd8
   } status_type;

   // Verdict handed from the parser to the counter stage
   typedef struct packed {
      logic             drop;
      status_type       status;
      logic [LEN_W-1:0] frame_length;
   } verdict_type;

endpackage

`default_nettype wire

@@ sv/udpf_ifs.sv @@
// Valid/ready channel interfaces for frame bytes in and verdicts out.
`default_nettype none

interface udpf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface udpf_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            drop;
   logic [3:0]                      status;
   logic [udpf_pkg::LEN_W-1:0]      frame_length;
   logic [udpf_pkg::CNT_W-1:0]      pass_total;
   logic [udpf_pkg::CNT_W-1:0]      drop_total;
   logic [udpf_pkg::CNT_W-1:0]      byte_total;

   modport source (output valid, output drop, output status, output frame_length,
                   output pass_total, output drop_total, output byte_total,
                   input ready);
   modport sink (input valid, input drop, input status, input frame_length,
                 input pass_total, input drop_total, input byte_total,
                 output ready);
endinterface

`default_nettype wire

@@ sv/udpf_parse.sv @@
// Byte input register, header field capture and per-frame verdict register.
`default_nettype none

module udpf_parse (
   input  wire logic                 clock,
   input  wire logic                 reset,
   udpf_req_if.sink                  req_channel,
   input  wire logic                 csr_write_enable,
   input  wire logic                 csr_index,
   input  wire logic [15:0]          csr_data,
   output logic                      vrd_valid,
   output udpf_pkg::verdict_type     vrd_data,
   input  wire logic                 vrd_ready
);
   import udpf_pkg::*;

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Per-frame state
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [15:0]       etype_ff, etype_in;
   logic [3:0]        hw_ff, hw_in;
   logic [15:0]       frag_ff, frag_in;
   logic [7:0]        proto_ff, proto_in;
   logic [PORT_W-1:0] dport_ff, dport_in;

   // Configuration
   logic              enable_ff;
   logic [PORT_W-1:0] target_ff;

   // Verdict register
   logic        vrd_valid_ff, vrd_valid_in;
   verdict_type vrd_ff, vrd_in;

   logic             in_go, vrd_free;
   logic [L4_W-1:0]  l4_cur, l4_new;
   logic [LEN_W-1:0] l4_cur_w, l4_new_w, len;
   status_type       status;

   // Handshake: a non-last byte only updates state; a last byte needs the verdict slot
   assign vrd_free = !vrd_valid_ff || vrd_ready;
   assign in_go = in_valid_ff && (!in_last_ff || vrd_free);
   assign req_channel.ready = !in_valid_ff || in_go;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_channel.valid && req_channel.ready) begin
         in_valid_in = 1'b1;
      end else if (in_go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_channel.valid && req_channel.ready) begin
         in_byte_ff <= req_channel.data_byte;
         in_last_ff <= req_channel.last_byte;
      end
   end

   // Field capture at the current byte position
   assign l4_cur = L4_BASE + {1'b0, hw_ff, 2'b00};
   assign l4_cur_w = LEN_W'(l4_cur);

   always_comb begin
      etype_in = etype_ff;
      hw_in = hw_ff;
      frag_in = frag_ff;
      proto_in = proto_ff;
      dport_in = dport_ff;
      if (pos_ff == POS_ETYPE_HI) begin
         etype_in[15:8] = in_byte_ff;
      end else if (pos_ff == POS_ETYPE_LO) begin
         etype_in[7:0] = in_byte_ff;
      end else if (pos_ff == POS_IHL) begin
         hw_in = in_byte_ff[3:0];
      end else if (pos_ff == POS_FRAG_HI) begin
         frag_in[15:8] = in_byte_ff;
      end else if (pos_ff == POS_FRAG_LO) begin
         frag_in[7:0] = in_byte_ff;
      end else if (pos_ff == POS_PROTO) begin
         proto_in = in_byte_ff;
      end
      if (pos_ff >= POS_L4_MIN) begin
         if (pos_ff == l4_cur_w + LEN_W'(2)) begin
            dport_in[15:8] = in_byte_ff;
         end else if (pos_ff == l4_cur_w + LEN_W'(3)) begin
            dport_in[7:0] = in_byte_ff;
         end
      end
      pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + LEN_W'(1);
   end

   // Frame verdict from the fields including this byte
   assign len = pos_in;
   assign l4_new = L4_BASE + {1'b0, hw_in, 2'b00};
   assign l4_new_w = LEN_W'(l4_new);

   always_comb begin
      status = ST_PASS;
      if (len < ETH_LEN) begin
         status = ST_SHORT_ETH;
      end else if (etype_in != ETHERTYPE_IPV4) begin
         status = ST_NOT_IPV4;
      end else if (len < ETH_IP_MIN) begin
         status = ST_SHORT_IP;
      end else if (hw_in < IHL_MIN) begin
         status = ST_BAD_IHL;
      end else if (l4_new_w > len) begin
         status = ST_OPT_PAST;
      end else if ((frag_in & FRAG_MASK) != 16'h0000) begin
         status = ST_FRAGMENT;
      end else if (proto_in == PROTO_TCP) begin
         if (l4_new_w + TCP_LEN > len) begin
            status = ST_SHORT_L4;
         end
      end else if (proto_in == PROTO_UDP) begin
         if (l4_new_w + UDP_LEN > len) begin
            status = ST_SHORT_L4;
         end else if (enable_ff && dport_in == target_ff) begin
            status = ST_DROP;
         end
      end
      vrd_in.drop = (status == ST_DROP);
      vrd_in.status = status;
      vrd_in.frame_length = len;
   end

   always_comb begin
      vrd_valid_in = vrd_valid_ff;
      if (in_go && in_last_ff) begin
         vrd_valid_in = 1'b1;
      end else if (vrd_ready) begin
         vrd_valid_in = 1'b0;
      end
   end

   // Frame state: advance per byte, clear at frame end
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         etype_ff <= '0;
         hw_ff <= '0;
         frag_ff <= '0;
         proto_ff <= '0;
         dport_ff <= '0;
      end else if (in_go) begin
         if (in_last_ff) begin
            pos_ff <= '0;
            etype_ff <= '0;
            hw_ff <= '0;
            frag_ff <= '0;
            proto_ff <= '0;
            dport_ff <= '0;
         end else begin
            pos_ff <= pos_in;
            etype_ff <= etype_in;
            hw_ff <= hw_in;
            frag_ff <= frag_in;
            proto_ff <= proto_in;
            dport_ff <= dport_in;
         end
      end
   end

   // Verdict register
   always_ff @(posedge clock) begin
      if (reset) begin
         vrd_valid_ff <= 1'b0;
      end else begin
         vrd_valid_ff <= vrd_valid_in;
      end
      if (in_go && in_last_ff) begin
         vrd_ff <= vrd_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         target_ff <= DEFAULT_PORT;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FILTER_ENABLE: enable_ff <= csr_data[0];
            CSR_TARGET_PORT:   target_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign vrd_valid = vrd_valid_ff;
   assign vrd_data = vrd_ff;

   // Checks
   a_drop_code: assert property (@(posedge clock) disable iff (reset)
      vrd_valid_ff |-> (vrd_ff.drop == (vrd_ff.status == ST_DROP)))
      else $error("verdict drop flag disagrees with status");
   a_state_clear: assert property (@(posedge clock) disable iff (reset)
      (in_go && in_last_ff) |=> (pos_ff == '0 && hw_ff == '0 && etype_ff == '0))
      else $error("frame state not cleared after last byte");
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      (in_go && !in_last_ff && pos_ff != POS_MAX) |=> (pos_ff == $past(pos_ff) + LEN_W'(1)))
      else $error("byte position did not advance");

endmodule

`default_nettype wire

@@ sv/udpf_count.sv @@
// Pass, drop and byte counters with the result output register.
`default_nettype none

module udpf_count (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 vrd_valid,
   input  wire udpf_pkg::verdict_type vrd_data,
   output logic                      vrd_ready,
   udpf_rsp_if.source                rsp_channel
);
   import udpf_pkg::*;

   logic [CNT_W-1:0] pass_ff, pass_in;
   logic [CNT_W-1:0] drop_ff, drop_in;
   logic [CNT_W-1:0] bytes_ff, bytes_in;
   logic             out_valid_ff, out_valid_in;
   verdict_type      out_vrd_ff;
   logic             vrd_go, counted;

   assign vrd_ready = !out_valid_ff || rsp_channel.ready;
   assign vrd_go = vrd_valid && vrd_ready;
   assign counted = (vrd_data.status == ST_PASS) || (vrd_data.status == ST_DROP);

   // Counter update for frames with a pass or drop verdict
   always_comb begin
      pass_in = pass_ff;
      drop_in = drop_ff;
      bytes_in = bytes_ff;
      if (vrd_go && counted) begin
         bytes_in = bytes_ff + CNT_W'(vrd_data.frame_length);
         if (vrd_data.status == ST_DROP) begin
            drop_in = drop_ff + CNT_W'(1);
         end else begin
            pass_in = pass_ff + CNT_W'(1);
         end
      end
      out_valid_in = out_valid_ff;
      if (vrd_go) begin
         out_valid_in = 1'b1;
      end else if (rsp_channel.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= '0;
         drop_ff <= '0;
         bytes_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pass_ff <= pass_in;
         drop_ff <= drop_in;
         bytes_ff <= bytes_in;
         out_valid_ff <= out_valid_in;
      end
      if (vrd_go) begin
         out_vrd_ff <= vrd_data;
      end
   end

   // Result register: totals are the counters as they stand after this frame
   assign rsp_channel.valid = out_valid_ff;
   assign rsp_channel.drop = out_vrd_ff.drop;
   assign rsp_channel.status = out_vrd_ff.status;
   assign rsp_channel.frame_length = out_vrd_ff.frame_length;
   assign rsp_channel.pass_total = pass_ff;
   assign rsp_channel.drop_total = drop_ff;
   assign rsp_channel.byte_total = bytes_ff;

   // Checks
   a_pass_bump: assert property (@(posedge clock) disable iff (reset)
      (vrd_go && vrd_data.status == ST_PASS) |=> (pass_ff == $past(pass_ff) + CNT_W'(1)))
      else $error("pass counter missed a counted pass");
   a_drop_bump: assert property (@(posedge clock) disable iff (reset)
      (vrd_go && vrd_data.status == ST_DROP) |=> (drop_ff == $past(drop_ff) + CNT_W'(1)))
      else $error("drop counter missed a counted drop");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !vrd_go |=> ($stable(pass_ff) && $stable(drop_ff) && $stable(bytes_ff)))
      else $error("counters moved without a verdict transfer");

endmodule

`default_nettype wire

@@ sv/ipv4_udp_port_drop_filter.sv @@
// Top level: IPv4 TCP/UDP ingress filter, one frame byte per transfer.
// Throughput: one byte per cycle; a byte is taken every cycle unless a last byte waits in the input
// register while both the verdict and result registers hold results the sink has not taken.
// A frame's last byte enters the input register; its verdict then passes the verdict
// register and then the result register.
// Reset (synchronous, active high): empties the pipeline, clears frame state and
// counters, filter_enable = 0, target_port = 5201.
`default_nettype none

module ipv4_udp_port_drop_filter (
   input  wire logic        clock,
   input  wire logic        reset,
   udpf_req_if.sink         req_channel,
   udpf_rsp_if.source       rsp_channel,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data
);
   import udpf_pkg::*;

   logic        vrd_valid;
   logic        vrd_ready;
   verdict_type vrd_data;

   // Header parse and verdict
   udpf_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_channel),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .vrd_valid        (vrd_valid),
      .vrd_data         (vrd_data),
      .vrd_ready        (vrd_ready)
   );

   // Counters and result register
   udpf_count u_count (
      .clock       (clock),
      .reset       (reset),
      .vrd_valid   (vrd_valid),
      .vrd_data    (vrd_data),
      .vrd_ready   (vrd_ready),
      .rsp_channel (rsp_channel)
   );

endmodule

`default_nettype wire
